FILE: rtl/iuic_pkg.sv
// Package for the image upload integrity checker.
// Holds the request and result types, the error and register codes,
// and the bytewise CRC-32 update function. It depends on nothing.
package iuic_pkg;

  // Build constants
  localparam int SLOT_COUNT  = 4;
  localparam int HEADER_KEEP = 10;

  localparam logic [7:0]  TARGET_SD      = 8'd0;
  localparam logic [7:0]  TARGET_FLASH   = 8'd2;
  localparam logic [31:0] GZIP_MIN       = 32'd18;
  localparam logic [7:0]  GZIP_ID1       = 8'h1f;
  localparam logic [7:0]  GZIP_ID2       = 8'h8b;
  localparam logic [7:0]  GZIP_DEFLATE   = 8'd8;
  localparam logic [7:0]  GZIP_FLG_RSVD  = 8'he0;
  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
  localparam logic [31:0] IMAGE_LEN_RST  = 32'd9730652;
  localparam logic [31:0] SLOT_CAP_RST   = 32'd2097152;

  // Command codes
  typedef enum logic [1:0] {
    MODE_BEGIN = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_END   = 2'd2,
    MODE_ABORT = 2'd3
  } mode_t;

  // Error codes reported with each result
  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_ACTIVE     = 4'd1,
    ERR_TARGET     = 4'd2,
    ERR_SLOT       = 4'd3,
    ERR_SIZE       = 4'd4,
    ERR_CRC        = 4'd5,
    ERR_FLASH_SIZE = 4'd6,
    ERR_NO_SESSION = 4'd7,
    ERR_GZIP       = 4'd8
  } err_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SD_PRESENT    = 2'd0,
    CFG_IMAGE_LENGTH  = 2'd1,
    CFG_SLOT_CAPACITY = 2'd2
  } cfg_idx_t;

  // One command request
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  target;
    logic [7:0]  slot;
    logic [31:0] expected_length;
    logic [31:0] expected_checksum;
    logic [7:0]  data_byte;
  } item_t;

  // One result
  typedef struct packed {
    err_t        error_code;
    logic        session_active;
    logic [31:0] bytes_received;
    logic        upload_complete;
  } result_t;

  // Configuration register contents
  typedef struct packed {
    logic        sd_present;
    logic [31:0] image_length;
    logic [31:0] slot_capacity;
  } cfg_t;

  // Reflected CRC-32 update with one byte, LSB first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/iuic_cfg_regs.sv
// Configuration registers of the image upload integrity checker.
// Decodes the configuration write channel into the cfg_t struct.
// Depends on iuic_pkg.
module iuic_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output iuic_pkg::cfg_t     cfg
);

  iuic_pkg::cfg_t cfg_r;

  // Writes are taken in every cycle.
  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Register file; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sd_present    <= 1'b0;
      cfg_r.image_length  <= iuic_pkg::IMAGE_LEN_RST;
      cfg_r.slot_capacity <= iuic_pkg::SLOT_CAP_RST;
    end else if (cfg_valid) begin
      case (iuic_pkg::cfg_idx_t'(cfg_index))
        iuic_pkg::CFG_SD_PRESENT:    cfg_r.sd_present    <= cfg_data[0];
        iuic_pkg::CFG_IMAGE_LENGTH:  cfg_r.image_length  <= cfg_data;
        iuic_pkg::CFG_SLOT_CAPACITY: cfg_r.slot_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/iuic_engine.sv
// Session state and per-request check logic of the upload checker.
// Computes the result of the request held in the input register and
// updates the session state when that request advances. Depends on iuic_pkg.
module iuic_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  iuic_pkg::item_t     item,
  input  iuic_pkg::cfg_t      cfg,
  output iuic_pkg::result_t   result
);

  logic        active_r,   active_nxt;
  logic [7:0]  target_r,   target_nxt;
  logic [31:0] len_goal_r, len_goal_nxt;
  logic [31:0] crc_goal_r, crc_goal_nxt;
  logic [31:0] count_r,    count_nxt;
  logic [31:0] crc_r,      crc_nxt;
  logic [7:0]  hdr_r [4];
  logic [7:0]  hdr_nxt [4];
  logic [3:0]  hdr_cnt_r,  hdr_cnt_nxt;
  logic [31:0] trail_r,    trail_nxt;
  iuic_pkg::err_t err_r,   err_nxt;
  logic        done;
  logic        gzip_ok;
  logic [31:0] crc_upd;

  assign crc_upd = iuic_pkg::crc32_byte(crc_r, item.data_byte);

  // Shape of a complete gzip stream as captured so far.
  assign gzip_ok = (count_r >= iuic_pkg::GZIP_MIN) &&
                   (hdr_cnt_r == 4'(iuic_pkg::HEADER_KEEP)) &&
                   (hdr_r[0] == iuic_pkg::GZIP_ID1) &&
                   (hdr_r[1] == iuic_pkg::GZIP_ID2) &&
                   (hdr_r[2] == iuic_pkg::GZIP_DEFLATE) &&
                   ((hdr_r[3] & iuic_pkg::GZIP_FLG_RSVD) == 8'd0) &&
                   (trail_r == cfg.image_length);

  // Next session state for the current request.
  always_comb begin
    active_nxt   = active_r;
    target_nxt   = target_r;
    len_goal_nxt = len_goal_r;
    crc_goal_nxt = crc_goal_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    hdr_nxt      = hdr_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    trail_nxt    = trail_r;
    err_nxt      = err_r;
    done         = 1'b0;
    case (item.mode)
      iuic_pkg::MODE_BEGIN: begin
        if (active_r) begin
          err_nxt = iuic_pkg::ERR_ACTIVE;
        end else begin
          // Session fields load and checks clear even if the begin fails.
          target_nxt   = item.target;
          len_goal_nxt = item.expected_length;
          crc_goal_nxt = item.expected_checksum;
          count_nxt    = 32'd0;
          crc_nxt      = iuic_pkg::CRC_INIT;
          hdr_nxt      = '{default: 8'd0};
          hdr_cnt_nxt  = 4'd0;
          trail_nxt    = 32'd0;
          err_nxt      = iuic_pkg::ERR_NONE;
          if (item.slot >= 8'(iuic_pkg::SLOT_COUNT)) begin
            err_nxt = iuic_pkg::ERR_SLOT;
          end else if (item.target == iuic_pkg::TARGET_SD) begin
            if (!cfg.sd_present) err_nxt = iuic_pkg::ERR_TARGET;
            else                 active_nxt = 1'b1;
          end else if (item.target == iuic_pkg::TARGET_FLASH) begin
            if (item.expected_length < iuic_pkg::GZIP_MIN ||
                item.expected_length > cfg.slot_capacity) begin
              err_nxt = iuic_pkg::ERR_FLASH_SIZE;
            end else begin
              active_nxt = 1'b1;
            end
          end else begin
            err_nxt = iuic_pkg::ERR_TARGET;
          end
        end
      end
      iuic_pkg::MODE_DATA: begin
        if (!active_r) begin
          err_nxt = iuic_pkg::ERR_NO_SESSION;
        end else if (count_r >= len_goal_r) begin
          // The count never exceeds the goal, so this drops the byte.
          err_nxt = iuic_pkg::ERR_SIZE;
        end else begin
          if (target_r != iuic_pkg::TARGET_SD) begin
            if (hdr_cnt_r < 4'(iuic_pkg::HEADER_KEEP)) begin
              if (hdr_cnt_r < 4'd4) hdr_nxt[hdr_cnt_r[1:0]] = item.data_byte;
              hdr_cnt_nxt = hdr_cnt_r + 4'd1;
            end
            trail_nxt = {item.data_byte, trail_r[31:8]};
          end
          crc_nxt   = crc_upd;
          count_nxt = count_r + 32'd1;
          err_nxt   = iuic_pkg::ERR_NONE;
        end
      end
      iuic_pkg::MODE_END: begin
        if (!active_r) begin
          err_nxt = iuic_pkg::ERR_NO_SESSION;
        end else if (count_r != len_goal_r) begin
          err_nxt = iuic_pkg::ERR_SIZE;
        end else if (~crc_r != crc_goal_r) begin
          err_nxt = iuic_pkg::ERR_CRC;
        end else if (target_r == iuic_pkg::TARGET_FLASH && !gzip_ok) begin
          err_nxt = iuic_pkg::ERR_GZIP;
        end else begin
          active_nxt = 1'b0;
          err_nxt    = iuic_pkg::ERR_NONE;
          done       = 1'b1;
        end
      end
      iuic_pkg::MODE_ABORT: begin
        active_nxt = 1'b0;
        err_nxt    = iuic_pkg::ERR_NONE;
      end
      default: ;
    endcase
  end

  // Result of the current request.
  always_comb begin
    result.error_code      = err_nxt;
    result.session_active  = active_nxt;
    result.bytes_received  = count_nxt;
    result.upload_complete = done;
  end

  // Session state register, updated when the request advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      target_r   <= 8'd0;
      len_goal_r <= 32'd0;
      crc_goal_r <= 32'd0;
      count_r    <= 32'd0;
      crc_r      <= iuic_pkg::CRC_INIT;
      hdr_r      <= '{default: 8'd0};
      hdr_cnt_r  <= 4'd0;
      trail_r    <= 32'd0;
      err_r      <= iuic_pkg::ERR_NONE;
    end else if (adv) begin
      active_r   <= active_nxt;
      target_r   <= target_nxt;
      len_goal_r <= len_goal_nxt;
      crc_goal_r <= crc_goal_nxt;
      count_r    <= count_nxt;
      crc_r      <= crc_nxt;
      hdr_r      <= hdr_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      trail_r    <= trail_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

FILE: rtl/image_upload_integrity_checker_top.sv
// Image upload integrity checker, top level.
// A request accepted into the input register has its result written to the result register when it advances.
// Throughput: one request per cycle; the input register, the session logic
// and the result register form a two-stage pipeline that stalls only on out_ready.
// Reset (rst_n low, synchronous) empties both stages, closes any session and
// loads the configuration registers with their defaults. Depends on iuic_pkg.
module image_upload_integrity_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_target,
  input  logic [7:0]  in_slot,
  input  logic [31:0] in_expected_length,
  input  logic [31:0] in_expected_checksum,
  input  logic [7:0]  in_data_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_error_code,
  output logic        out_session_active,
  output logic [31:0] out_bytes_received,
  output logic        out_upload_complete,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  iuic_pkg::item_t   item_r;
  logic              item_vld_r;
  iuic_pkg::result_t res_r;
  logic              res_vld_r;
  iuic_pkg::result_t res_nxt;
  iuic_pkg::cfg_t    cfg;
  logic              adv;

  // Pipeline flow control.
  assign adv      = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || adv;

  iuic_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  iuic_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (item_r),
    .cfg    (cfg),
    .result (res_nxt)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.mode              <= iuic_pkg::mode_t'(in_mode);
      item_r.target            <= in_target;
      item_r.slot              <= in_slot;
      item_r.expected_length   <= in_expected_length;
      item_r.expected_checksum <= in_expected_checksum;
      item_r.data_byte         <= in_data_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = res_vld_r;
  assign out_error_code      = res_r.error_code;
  assign out_session_active  = res_r.session_active;
  assign out_bytes_received  = res_r.bytes_received;
  assign out_upload_complete = res_r.upload_complete;

endmodule

FILE: dv/tb_image_upload_integrity_checker_top.sv
// Self-checking testbench for the image upload integrity checker.
// Drives begin, data, end and abort requests with random idling on both channels and
// checks every result against an in-bench session model. Depends on iuic_pkg and the RTL.
module tb_image_upload_integrity_checker_top;
  timeunit 1ns;
  timeprecision 1ps;
  import iuic_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 190;

  // Ways a generated upload session departs from a clean one
  typedef enum int {
    FLAW_NONE,
    FLAW_CRC,
    FLAW_GZIP,
    FLAW_EARLY_END,
    FLAW_EXTRA,
    FLAW_REBEGIN,
    FLAW_ABORT
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [7:0]  in_target = '0;
  logic [7:0]  in_slot = '0;
  logic [31:0] in_expected_length = '0;
  logic [31:0] in_expected_checksum = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_error_code;
  logic        out_session_active;
  logic [31:0] out_bytes_received;
  logic        out_upload_complete;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Request stream, expected outcomes and bookkeeping
  item_t   pending_q[$];
  result_t outcome_q[$];
  int      items_queued = 0;
  int      items_taken = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      in_gap = 0;
  int      in_calm = 0;
  int      out_wait = 0;
  int      out_calm = 0;
  logic    in_took = 1'b0;
  logic    out_took = 1'b0;

  // Shadow of the configuration registers
  logic        sh_sd_present;
  logic [31:0] sh_image_len;
  logic [31:0] sh_slot_cap;

  // Session model state
  logic        sess_open;
  logic [7:0]  sess_target;
  logic [7:0]  sess_slot;
  logic [31:0] goal_len;
  logic [31:0] goal_crc;
  logic [31:0] rx_count;
  logic [31:0] crc_acc;
  logic [7:0]  hdr_byte [0:3];
  int          hdr_seen;
  logic [31:0] tail_word;
  err_t        sess_err;

  image_upload_integrity_checker_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_target            (in_target),
    .in_slot              (in_slot),
    .in_expected_length   (in_expected_length),
    .in_expected_checksum (in_expected_checksum),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_error_code       (out_error_code),
    .out_session_active   (out_session_active),
    .out_bytes_received   (out_bytes_received),
    .out_upload_complete  (out_upload_complete),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #5 clk = ~clk;

  // Reflected CRC-32, one data bit per pass, LSB first.
  function automatic logic [31:0] crc32_advance(input logic [31:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c = {1'b0, c[31:1]};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Restart the running byte count, CRC and gzip capture.
  function automatic void clear_rx();
    rx_count = '0;
    crc_acc = CRC_INIT;
    for (int i = 0; i < 4; i++) hdr_byte[i] = '0;
    hdr_seen = 0;
    tail_word = '0;
  endfunction

  // Apply one request to the session model and return the result it produces.
  function automatic result_t upload_outcome(input item_t req);
    result_t res;
    logic    gzip_ok;
    res.upload_complete = 1'b0;
    case (req.mode)
      MODE_BEGIN: begin
        if (sess_open) begin
          sess_err = ERR_ACTIVE;
        end else begin
          // Session fields load even when a check below rejects the begin.
          sess_target = req.target;
          sess_slot = req.slot;
          goal_len = req.expected_length;
          goal_crc = req.expected_checksum;
          clear_rx();
          if (sess_slot >= SLOT_COUNT) sess_err = ERR_SLOT;
          else if (sess_target == TARGET_SD) sess_err = sh_sd_present ? ERR_NONE : ERR_TARGET;
          else if (sess_target == TARGET_FLASH)
            sess_err = (goal_len < GZIP_MIN || goal_len > sh_slot_cap) ? ERR_FLASH_SIZE
                                                                      : ERR_NONE;
          else sess_err = ERR_TARGET;
          sess_open = (sess_err == ERR_NONE);
        end
      end
      MODE_DATA: begin
        if (!sess_open) begin
          sess_err = ERR_NO_SESSION;
        end else if ({1'b0, rx_count} + 33'd1 > {1'b0, goal_len}) begin
          sess_err = ERR_SIZE;
        end else begin
          // Only the flash target captures gzip header and trailer bytes.
          if (sess_target != TARGET_SD) begin
            if (hdr_seen < HEADER_KEEP) begin
              if (hdr_seen < 4) hdr_byte[hdr_seen] = req.data_byte;
              hdr_seen++;
            end
            tail_word = {req.data_byte, tail_word[31:8]};
          end
          crc_acc = crc32_advance(crc_acc, req.data_byte);
          rx_count = rx_count + 32'd1;
          sess_err = ERR_NONE;
        end
      end
      MODE_END: begin
        gzip_ok = rx_count >= GZIP_MIN && hdr_seen == HEADER_KEEP &&
                  hdr_byte[0] == GZIP_ID1 && hdr_byte[1] == GZIP_ID2 &&
                  hdr_byte[2] == GZIP_DEFLATE && (hdr_byte[3] & GZIP_FLG_RSVD) == 8'd0 &&
                  tail_word == sh_image_len;
        if (!sess_open) sess_err = ERR_NO_SESSION;
        else if (rx_count != goal_len) sess_err = ERR_SIZE;
        else if (~crc_acc != goal_crc) sess_err = ERR_CRC;
        else if (sess_target == TARGET_FLASH && !gzip_ok) sess_err = ERR_GZIP;
        else begin
          sess_open = 1'b0;
          sess_err = ERR_NONE;
          res.upload_complete = 1'b1;
        end
      end
      default: begin
        sess_open = 1'b0;
        sess_err = ERR_NONE;
      end
    endcase
    res.error_code = sess_err;
    res.session_active = sess_open;
    res.bytes_received = rx_count;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ERROR result %0d %s: got 0x%0h, want 0x%0h",
             $time, results_seen, what, got, want);
    mismatches++;
  endtask

  // Track accepted requests and register writes, and predict each outcome.
  always @(posedge clk) begin : handshake_observer
    item_t req;
    if (!rst_n) begin
      sh_sd_present = 1'b0;
      sh_image_len = IMAGE_LEN_RST;
      sh_slot_cap = SLOT_CAP_RST;
      sess_open = 1'b0;
      sess_target = '0;
      sess_slot = '0;
      goal_len = '0;
      goal_crc = '0;
      clear_rx();
      sess_err = ERR_NONE;
      in_took <= 1'b0;
      items_taken <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SD_PRESENT:    sh_sd_present = cfg_data[0];
          CFG_IMAGE_LENGTH:  sh_image_len = cfg_data;
          CFG_SLOT_CAPACITY: sh_slot_cap = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        req.mode = mode_t'(in_mode);
        req.target = in_target;
        req.slot = in_slot;
        req.expected_length = in_expected_length;
        req.expected_checksum = in_expected_checksum;
        req.data_byte = in_data_byte;
        outcome_q.push_back(upload_outcome(req));
        items_taken <= items_taken + 1;
      end
      in_took <= in_valid && in_ready;
    end
  end

  // Compare each accepted result with the oldest expected outcome.
  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst_n) begin
      out_took <= 1'b0;
    end else begin
      out_took <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          flag_mismatch("result with no request pending", 32'(out_error_code), '0);
        end else begin
          want = outcome_q.pop_front();
          if (out_error_code !== want.error_code)
            flag_mismatch("error_code", 32'(out_error_code), 32'(want.error_code));
          if (out_session_active !== want.session_active)
            flag_mismatch("session_active", 32'(out_session_active),
                          32'(want.session_active));
          if (out_bytes_received !== want.bytes_received)
            flag_mismatch("bytes_received", out_bytes_received, want.bytes_received);
          if (out_upload_complete !== want.upload_complete)
            flag_mismatch("upload_complete", 32'(out_upload_complete),
                          32'(want.upload_complete));
        end
      end
    end
  end

  // Present pending requests, holding each until accepted, with random gaps.
  always @(negedge clk) begin : request_driver
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (in_valid && !in_took) begin
      // Request still waiting for in_ready; hold it.
    end else if (in_gap > 0) begin
      in_gap = in_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_q.size() != 0) begin
      nxt = pending_q.pop_front();
      in_mode <= nxt.mode;
      in_target <= nxt.target;
      in_slot <= nxt.slot;
      in_expected_length <= nxt.expected_length;
      in_expected_checksum <= nxt.expected_checksum;
      in_data_byte <= nxt.data_byte;
      in_valid <= 1'b1;
      if (in_calm > 0) begin
        in_calm = in_calm - 1;
        in_gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        in_calm = $urandom_range(10, 40);
        in_gap = 0;
      end else begin
        in_gap = $urandom_range(0, 17);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Stall the result channel for a random number of cycles per result.
  always @(negedge clk) begin : result_ready_driver
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_took) begin
        if (out_calm > 0) begin
          out_calm = out_calm - 1;
          out_wait = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          out_calm = $urandom_range(10, 40);
          out_wait = 0;
        end else begin
          out_wait = $urandom_range(0, 17);
        end
      end
      if (out_wait > 0) begin
        out_wait = out_wait - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // End the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ERROR watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_cmd(input mode_t m, input logic [7:0] tgt, input logic [7:0] slt,
                           input logic [31:0] len, input logic [31:0] csum,
                           input logic [7:0] b);
    item_t it;
    it.mode = m;
    it.target = tgt;
    it.slot = slt;
    it.expected_length = len;
    it.expected_checksum = csum;
    it.data_byte = b;
    pending_q.push_back(it);
    items_queued++;
  endtask

  // Data, abort and stray begin requests carry random bits in unused fields.
  task automatic queue_byte(input logic [7:0] b);
    queue_cmd(MODE_DATA, 8'($urandom), 8'($urandom), $urandom, $urandom, b);
  endtask

  task automatic queue_abort();
    queue_cmd(MODE_ABORT, 8'($urandom), 8'($urandom), $urandom, $urandom, 8'($urandom));
  endtask

  task automatic queue_stray_begin();
    queue_cmd(MODE_BEGIN, 8'($urandom), 8'($urandom), $urandom, $urandom, 8'($urandom));
  endtask

  // Wait until every queued request has its result checked, then let the pipe settle.
  task automatic wait_idle();
    while (items_taken != items_queued || outcome_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One upload session: begin, payload bytes and end, possibly with a flaw.
  task automatic queue_session();
    logic [7:0]  body[$];
    logic [7:0]  tgt;
    logic [31:0] n;
    logic [31:0] crc;
    flaw_t       flaw;
    int          nb;
    int          r;
    r = $urandom_range(0, 11);
    flaw = (r < 6) ? FLAW_NONE : flaw_t'(r - 5);
    tgt = ($urandom_range(0, 2) == 0) ? TARGET_SD : TARGET_FLASH;
    if (tgt == TARGET_FLASH) begin
      n = GZIP_MIN + 32'($urandom_range(0, 22));
      if (n > sh_slot_cap) n = sh_slot_cap;
      body.push_back(GZIP_ID1);
      body.push_back(GZIP_ID2);
      body.push_back(GZIP_DEFLATE);
      body.push_back({3'b000, 5'($urandom)});
      for (int j = 0; j < int'(n) - 8; j++) body.push_back(8'($urandom));
      body.push_back(sh_image_len[7:0]);
      body.push_back(sh_image_len[15:8]);
      body.push_back(sh_image_len[23:16]);
      body.push_back(sh_image_len[31:24]);
      // Break exactly one property of the gzip shape.
      if (flaw == FLAW_GZIP) begin
        case ($urandom_range(0, 4))
          0: body[0] = body[0] ^ (8'd1 << $urandom_range(0, 7));
          1: body[1] = body[1] ^ (8'd1 << $urandom_range(0, 7));
          2: body[2] = body[2] ^ (8'd1 << $urandom_range(0, 7));
          3: body[3] = body[3] | (8'h20 << $urandom_range(0, 2));
          default: begin
            nb = int'(n) - 1 - $urandom_range(0, 3);
            body[nb] = body[nb] ^ (8'd1 << $urandom_range(0, 7));
          end
        endcase
      end
    end else begin
      n = 32'($urandom_range(0, 24));
      for (int j = 0; j < int'(n); j++) body.push_back(8'($urandom));
    end
    crc = CRC_INIT;
    foreach (body[j]) crc = crc32_advance(crc, body[j]);
    crc = ~crc;
    if (flaw == FLAW_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    queue_cmd(MODE_BEGIN, tgt, 8'($urandom_range(0, SLOT_COUNT - 1)), n, crc,
              8'($urandom));
    nb = body.size();
    for (int j = 0; j < nb; j++) begin
      if (j == nb / 2) begin
        if (flaw == FLAW_REBEGIN) queue_stray_begin();
        if (flaw == FLAW_EARLY_END)
          queue_cmd(MODE_END, 8'($urandom), 8'($urandom), $urandom, $urandom, 8'($urandom));
        if (flaw == FLAW_ABORT) queue_abort();
      end
      queue_byte(body[j]);
    end
    if (flaw == FLAW_EXTRA) repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
    queue_cmd(MODE_END, 8'($urandom), 8'($urandom), $urandom, $urandom, 8'($urandom));
    if (flaw == FLAW_CRC || flaw == FLAW_GZIP || $urandom_range(0, 3) == 0) queue_abort();
  endtask

  // A short burst of random requests and begins aimed at the admission checks.
  task automatic queue_noise();
    logic [7:0]  tgt;
    logic [7:0]  slt;
    logic [31:0] len;
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1) == 0) begin
        queue_cmd(mode_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), $urandom,
                  $urandom, 8'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: tgt = TARGET_SD;
          1: tgt = TARGET_FLASH;
          2: tgt = 8'($urandom);
          default: tgt = 8'hFF;
        endcase
        case ($urandom_range(0, 3))
          0, 1: slt = 8'($urandom_range(0, SLOT_COUNT - 1));
          2: slt = 8'(SLOT_COUNT);
          default: slt = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0: len = '0;
          1: len = GZIP_MIN - 32'd1;
          2: len = GZIP_MIN;
          3: len = sh_slot_cap;
          4: len = sh_slot_cap + 32'd1;
          default: len = $urandom;
        endcase
        queue_cmd(MODE_BEGIN, tgt, slt, len, $urandom, 8'($urandom));
      end
    end
    if ($urandom_range(0, 3) != 0) queue_abort();
  endtask

  // Reset, directed requests, then random phases under different register settings.
  initial begin : stimulus
    int phase_first;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: admission checks with the reset settings (no SD card).
    queue_cmd(MODE_DATA, 8'd0, 8'd0, 32'd0, 32'd0, 8'h00);
    queue_cmd(MODE_END, 8'd0, 8'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(MODE_ABORT, 8'd0, 8'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(MODE_BEGIN, TARGET_FLASH, 8'(SLOT_COUNT), GZIP_MIN, 32'd0, 8'd0);
    queue_cmd(MODE_BEGIN, TARGET_SD, 8'hFF, 32'd0, 32'd0, 8'd0);
    queue_cmd(MODE_BEGIN, TARGET_SD, 8'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(MODE_BEGIN, 8'd1, 8'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(MODE_BEGIN, 8'hFF, 8'd3, 32'd0, 32'd0, 8'd0);
    queue_cmd(MODE_BEGIN, TARGET_FLASH, 8'd0, GZIP_MIN - 32'd1, 32'd0, 8'd0);
    queue_cmd(MODE_BEGIN, TARGET_FLASH, 8'd1, SLOT_CAP_RST + 32'd1, 32'd0, 8'd0);
    queue_cmd(MODE_BEGIN, TARGET_FLASH, 8'd2, 32'hFFFF_FFFF, 32'd0, 8'd0);
    // Largest flash length opens a session; a second begin is refused.
    queue_cmd(MODE_BEGIN, TARGET_FLASH, 8'd3, SLOT_CAP_RST, 32'hFFFF_FFFF, 8'd0);
    queue_cmd(MODE_BEGIN, TARGET_SD, 8'd0, 32'd5, 32'd0, 8'd0);
    queue_cmd(MODE_DATA, 8'd0, 8'd0, 32'd0, 32'd0, 8'hFF);
    queue_cmd(MODE_DATA, 8'd0, 8'd0, 32'd0, 32'd0, 8'h00);
    queue_cmd(MODE_END, 8'd0, 8'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(MODE_ABORT, 8'd0, 8'd0, 32'd0, 32'd0, 8'd0);
    wait_idle();

    // Directed with the card present: empty upload, dropped byte, open-ended length.
    write_reg(CFG_SD_PRESENT, 32'd1);
    queue_cmd(MODE_BEGIN, TARGET_SD, 8'd1, 32'd0, 32'd0, 8'd0);
    queue_cmd(MODE_DATA, 8'd0, 8'd0, 32'd0, 32'd0, 8'hA5);
    queue_cmd(MODE_END, 8'd0, 8'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(MODE_BEGIN, TARGET_SD, 8'd2, 32'hFFFF_FFFF, 32'h1234_5678, 8'd0);
    queue_cmd(MODE_DATA, 8'd0, 8'd0, 32'd0, 32'd0, 8'h5A);
    queue_cmd(MODE_END, 8'd0, 8'd0, 32'd0, 32'd0, 8'd0);
    queue_cmd(MODE_ABORT, 8'd0, 8'd0, 32'd0, 32'd0, 8'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(CFG_SD_PRESENT, ($urandom & 32'hFFFF_FFFE) | 32'd1);
          write_reg(CFG_IMAGE_LENGTH, $urandom);
          write_reg(CFG_SLOT_CAPACITY, SLOT_CAP_RST);
        end
        1: begin
          write_reg(CFG_SD_PRESENT, $urandom & 32'hFFFF_FFFE);
          write_reg(CFG_IMAGE_LENGTH, 32'd0);
          write_reg(CFG_SLOT_CAPACITY, GZIP_MIN);
        end
        2: begin
          write_reg(CFG_SD_PRESENT, 32'd1);
          write_reg(CFG_IMAGE_LENGTH, 32'hFFFF_FFFF);
          write_reg(CFG_SLOT_CAPACITY, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(CFG_SD_PRESENT, 32'hFFFF_FFFF);
          write_reg(CFG_IMAGE_LENGTH, $urandom);
          write_reg(CFG_SLOT_CAPACITY, 32'($urandom_range(18, 40)));
        end
        default: begin
          write_reg(CFG_SD_PRESENT, $urandom);
          write_reg(CFG_IMAGE_LENGTH, $urandom);
          write_reg(CFG_SLOT_CAPACITY, 32'($urandom_range(18, 64)));
        end
      endcase
      phase_first = items_queued;
      while (items_queued - phase_first < PHASE_ITEMS / 2) begin
        if ($urandom_range(0, 4) != 0) queue_session();
        else queue_noise();
      end
      // Hold off new requests until every result so far has come back.
      wait_idle();
      while (items_queued - phase_first < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) queue_session();
        else queue_noise();
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/iuic_pkg.sv
rtl/iuic_cfg_regs.sv
rtl/iuic_engine.sv
rtl/image_upload_integrity_checker_top.sv
dv/tb_image_upload_integrity_checker_top.sv
